// ----- design/cfr_pkg.sv -----
// shared types and constants of the command frame receiver
package cfr_pkg;

	localparam logic [7:0] SYNC_B0   = 8'hD7;
	localparam logic [7:0] SYNC_B1   = 8'hE5;
	localparam logic [7:0] SYNC_B2   = 8'h61;
	localparam logic [7:0] FRAME_ID  = 8'h01;
	localparam logic [7:0] SHORT_HDR = 8'h55;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_CHECK = 1'b1;

	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SYNC1,
		ST_SYNC2,
		ST_SYNC3,
		ST_CMD,
		ST_LEN,
		ST_BODY
	} parse_step_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_COPY,
		BK_FLUSH,
		BK_RESP
	} back_state_t;

	typedef enum logic [1:0] {
		OP_RESULT,
		OP_READ,
		OP_COPY
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic       accepted;
		logic       stored;
		logic       err;
		logic [7:0] cmd;
		logic [7:0] idx;
	} op_t;

endpackage

// ----- design/command_frame_receiver.sv -----
// top level of the command frame receiver
// Each item is either a link byte (tuser 0) for the frame parser or a read of the
// command table (tuser 1), and gives exactly one result item, in order. The parser
// accepts an item per cycle, while it is not busy and the queue is not full, into a
// two-entry queue; the table engine loads a plain result straight into its result
// register and serves a table read through its registered memory port. A byte that
// completes a stored frame holds off input while the frame buffer is copied into the
// table row one byte per cycle over its single write port. Rows carry a valid bit
// cleared at reset, so no clearing pass is needed and never-written row bytes read as zero.
module command_frame_receiver #(
	parameter int NUM_CMDS = 16,
	parameter int MAX_LEN  = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                            cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // rx_byte, cmd_index, byte_index
	input  logic                            s_tuser,   // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata    // accepted, frame_stored, checksum_error, read_data
);

	localparam int BUF_AW = $clog2(MAX_LEN + 3);

	logic                 q_push;
	cfr_pkg::op_t         q_wdata;
	logic                 q_full;
	logic                 q_rvalid;
	cfr_pkg::op_t         q_rdata;
	logic                 q_pop;
	logic                 copy_done;
	logic [BUF_AW-1:0]    buf_raddr;
	logic [7:0]           buf_rdata;

	cfr_front #(
		.NUM_CMDS (NUM_CMDS),
		.MAX_LEN  (MAX_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_push    (q_push),
		.q_wdata   (q_wdata),
		.q_full    (q_full),
		.copy_done (copy_done),
		.buf_raddr (buf_raddr),
		.buf_rdata (buf_rdata)
	);

	cfr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rvalid (q_rvalid),
		.rdata  (q_rdata),
		.pop    (q_pop)
	);

	cfr_back #(
		.NUM_CMDS (NUM_CMDS),
		.MAX_LEN  (MAX_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rvalid  (q_rvalid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.copy_done (copy_done),
		.buf_raddr (buf_raddr),
		.buf_rdata (buf_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- design/cfr_queue.sv -----
// two-entry queue between the parser and the table engine
module cfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cfr_pkg::op_t  wdata,
	output logic          full,
	output logic          rvalid,
	output cfr_pkg::op_t  rdata,
	input  logic          pop
);

	cfr_pkg::op_t                mem_q [cfr_pkg::Q_DEPTH];
	logic [cfr_pkg::Q_PW-1:0]    wptr_q;
	logic [cfr_pkg::Q_PW-1:0]    rptr_q;
	logic [cfr_pkg::Q_CW-1:0]    count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = count_q == cfr_pkg::Q_CW'(cfr_pkg::Q_DEPTH);
	assign rvalid  = count_q != '0;
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rvalid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (int'(wptr_q) == cfr_pkg::Q_DEPTH - 1) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (int'(rptr_q) == cfr_pkg::Q_DEPTH - 1) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/cfr_front.sv -----
// frame parser: accepts items, tracks the frame, fills the frame buffer
module cfr_front #(
	parameter int NUM_CMDS = 16,
	parameter int MAX_LEN  = 15,
	localparam int ROW_BYTES = MAX_LEN + 3,
	localparam int BUF_AW    = $clog2(ROW_BYTES)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                            cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,
	input  logic                            s_tuser,
	output logic                            q_push,
	output cfr_pkg::op_t                    q_wdata,
	input  logic                            q_full,
	input  logic                            copy_done,
	input  logic [BUF_AW-1:0]               buf_raddr,
	output logic [7:0]                      buf_rdata
);

	logic                  sync_mode_q;
	logic                  checksum_check_q;
	cfr_pkg::parse_step_t  step_q;
	cfr_pkg::parse_step_t  step_d;
	logic [7:0]            cmd_q;
	logic [7:0]            len_q;
	logic [7:0]            cnt_q;
	logic [7:0]            sum_q;
	logic                  busy_q;
	logic [7:0]            fbuf [ROW_BYTES];

	logic [7:0]            b;
	logic                  fire;
	logic                  link;
	logic                  hunt_hit;
	logic                  hunt_wr;
	cfr_pkg::parse_step_t  hunt_step;
	logic                  too_long;
	logic                  have_data;
	logic                  last_data;
	logic                  cmd_in_range;

	logic                  acc;
	logic                  finish;
	logic                  err;
	logic                  buf_we;
	logic [BUF_AW-1:0]     buf_waddr;
	logic [7:0]            sum_d;
	logic [7:0]            cmd_d;
	logic [7:0]            len_d;
	logic [7:0]            cnt_d;
	logic [7:0]            fin_len;
	logic                  stored;

	assign cfg_ready    = 1'b1;
	assign b            = s_tdata[7:0];
	assign s_tready     = !busy_q && !q_full;
	assign fire         = s_tvalid && s_tready;
	assign link         = fire && !s_tuser;
	assign hunt_hit     = sync_mode_q ? (b == cfr_pkg::SHORT_HDR) : (b == cfr_pkg::SYNC_B0);
	assign hunt_wr      = sync_mode_q && (b == cfr_pkg::SHORT_HDR);
	assign hunt_step    = !hunt_hit ? cfr_pkg::ST_HUNT :
	                      (sync_mode_q ? cfr_pkg::ST_CMD : cfr_pkg::ST_SYNC1);
	assign too_long     = int'(b) > MAX_LEN;
	assign have_data    = cnt_q < len_q;
	assign last_data    = ({1'b0, cnt_q} + 9'd1) >= {1'b0, len_q};
	assign cmd_in_range = int'(cmd_q) < NUM_CMDS;
	assign stored       = finish && cmd_in_range;

	always_comb begin
		step_d = step_q;
		if (link) begin
			unique case (step_q)
				cfr_pkg::ST_HUNT: step_d = hunt_step;
				cfr_pkg::ST_SYNC1: begin
					step_d = (!sync_mode_q && b == cfr_pkg::SYNC_B1) ? cfr_pkg::ST_SYNC2 : hunt_step;
				end
				cfr_pkg::ST_SYNC2: begin
					step_d = (!sync_mode_q && b == cfr_pkg::SYNC_B2) ? cfr_pkg::ST_SYNC3 : hunt_step;
				end
				cfr_pkg::ST_SYNC3: begin
					step_d = (!sync_mode_q && b == cfr_pkg::FRAME_ID) ? cfr_pkg::ST_CMD : hunt_step;
				end
				cfr_pkg::ST_CMD: step_d = cfr_pkg::ST_LEN;
				cfr_pkg::ST_LEN: begin
					if (too_long || (b == 8'd0 && !checksum_check_q)) begin
						step_d = cfr_pkg::ST_HUNT;
					end else begin
						step_d = cfr_pkg::ST_BODY;
					end
				end
				cfr_pkg::ST_BODY: begin
					if (have_data && !(last_data && !checksum_check_q)) begin
						step_d = cfr_pkg::ST_BODY;
					end else begin
						step_d = cfr_pkg::ST_HUNT;
					end
				end
				default: step_d = hunt_step;
			endcase
		end
	end

	always_comb begin
		acc       = 1'b0;
		finish    = 1'b0;
		err       = 1'b0;
		buf_we    = 1'b0;
		buf_waddr = '0;
		sum_d     = sum_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		fin_len   = len_q;
		if (link) begin
			unique case (step_q)
				cfr_pkg::ST_SYNC1, cfr_pkg::ST_SYNC2: begin
					if (!sync_mode_q && ((step_q == cfr_pkg::ST_SYNC1 && b == cfr_pkg::SYNC_B1) ||
					    (step_q == cfr_pkg::ST_SYNC2 && b == cfr_pkg::SYNC_B2))) begin
						acc = 1'b1;
					end else begin
						acc    = hunt_hit;
						buf_we = hunt_wr;
						sum_d  = hunt_wr ? b : sum_q;
					end
				end
				cfr_pkg::ST_SYNC3: begin
					if (!sync_mode_q && b == cfr_pkg::FRAME_ID) begin
						acc    = 1'b1;
						buf_we = 1'b1;
						sum_d  = b;
					end else begin
						acc    = hunt_hit;
						buf_we = hunt_wr;
						sum_d  = hunt_wr ? b : sum_q;
					end
				end
				cfr_pkg::ST_CMD: begin
					acc       = 1'b1;
					cmd_d     = b;
					buf_we    = 1'b1;
					buf_waddr = BUF_AW'(1);
					sum_d     = sum_q + b;
				end
				cfr_pkg::ST_LEN: begin
					if (!too_long) begin
						acc       = 1'b1;
						len_d     = b;
						buf_we    = 1'b1;
						buf_waddr = BUF_AW'(2);
						sum_d     = sum_q + b;
						cnt_d     = '0;
						fin_len   = b;
						finish    = (b == 8'd0) && !checksum_check_q;
					end
				end
				cfr_pkg::ST_BODY: begin
					if (have_data) begin
						acc       = 1'b1;
						buf_we    = 1'b1;
						buf_waddr = BUF_AW'(cnt_q) + BUF_AW'(3);
						sum_d     = sum_q + b;
						cnt_d     = cnt_q + 8'd1;
						finish    = last_data && !checksum_check_q;
					end else if (checksum_check_q) begin
						if (sum_q == b) begin
							acc    = 1'b1;
							finish = 1'b1;
						end else begin
							err = 1'b1;
						end
					end else begin
						acc    = 1'b1;
						finish = 1'b1;
					end
				end
				default: begin
					acc    = hunt_hit;
					buf_we = hunt_wr;
					sum_d  = hunt_wr ? b : sum_q;
				end
			endcase
		end
	end

	always_comb begin
		q_push           = fire;
		q_wdata.accepted = acc;
		q_wdata.stored   = stored;
		q_wdata.err      = err;
		if (s_tuser) begin
			q_wdata.kind = cfr_pkg::OP_READ;
			q_wdata.cmd  = {4'd0, s_tdata[11:8]};
			q_wdata.idx  = {4'd0, s_tdata[15:12]};
		end else begin
			q_wdata.kind = stored ? cfr_pkg::OP_COPY : cfr_pkg::OP_RESULT;
			q_wdata.cmd  = cmd_q;
			q_wdata.idx  = fin_len;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			fbuf[buf_waddr] <= b;
		end
		buf_rdata <= fbuf[buf_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_mode_q      <= 1'b1;
			checksum_check_q <= 1'b0;
			step_q           <= cfr_pkg::ST_HUNT;
			cmd_q            <= '0;
			len_q            <= '0;
			cnt_q            <= '0;
			sum_q            <= '0;
			busy_q           <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					cfr_pkg::CFG_SYNC_MODE:      sync_mode_q      <= cfg_data;
					cfr_pkg::CFG_CHECKSUM_CHECK: checksum_check_q <= cfg_data;
				endcase
			end
			step_q <= step_d;
			cmd_q  <= cmd_d;
			len_q  <= len_d;
			cnt_q  <= cnt_d;
			sum_q  <= sum_d;
			if (link && stored) begin
				busy_q <= 1'b1;
			end else if (copy_done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/cfr_back.sv -----
// table engine: serves reads, copies finished frames, drives the result register
module cfr_back #(
	parameter int NUM_CMDS = 16,
	parameter int MAX_LEN  = 15,
	localparam int ROW_BYTES = MAX_LEN + 3,
	localparam int BUF_AW    = $clog2(ROW_BYTES),
	localparam int DEPTH     = NUM_CMDS * ROW_BYTES,
	localparam int AW        = $clog2(DEPTH),
	localparam int ROW_IW    = (NUM_CMDS > 1) ? $clog2(NUM_CMDS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_rvalid,
	input  cfr_pkg::op_t         q_rdata,
	output logic                 q_pop,
	output logic                 copy_done,
	output logic [BUF_AW-1:0]    buf_raddr,
	input  logic [7:0]           buf_rdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata
);

	cfr_pkg::back_state_t  state_q;
	cfr_pkg::back_state_t  state_d;
	cfr_pkg::op_t          cur_q;
	logic [7:0]            table_mem [DEPTH];
	logic [7:0]            mem_q;
	logic                  rd_ok_s1;
	logic [NUM_CMDS-1:0]   row_valid_q;
	logic                  row_was_valid_q;
	logic [BUF_AW-1:0]     col_q;
	logic [BUF_AW-1:0]     col_s1;
	logic                  wr_s1;

	logic                  out_valid_q;
	logic                  out_acc_q;
	logic                  out_stored_q;
	logic                  out_err_q;
	logic [7:0]            out_data_q;

	logic                  out_free;
	logic                  rd_ok;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic                  wr_fire;
	logic                  col_in_frame;
	logic [ROW_IW-1:0]     row_idx;
	logic                  load_out;
	logic                  load_acc;
	logic                  load_stored;
	logic                  load_err;
	logic [7:0]            load_data;

	assign out_free     = !out_valid_q || m_tready;
	assign row_idx      = ROW_IW'(cur_q.cmd);
	assign rd_ok        = int'(q_rdata.cmd) < NUM_CMDS && int'(q_rdata.idx) + 2 < ROW_BYTES &&
	                      row_valid_q[ROW_IW'(q_rdata.cmd)];
	assign rd_addr      = AW'(q_rdata.cmd) * AW'(ROW_BYTES) + AW'(q_rdata.idx) + AW'(2);
	assign wr_addr      = AW'(cur_q.cmd) * AW'(ROW_BYTES) + AW'(col_s1);
	assign col_in_frame = int'(col_s1) < int'(cur_q.idx) + 3;
	assign wr_fire      = wr_s1 && (col_in_frame || !row_was_valid_q);
	assign buf_raddr    = col_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_data_q, out_err_q, out_stored_q, out_acc_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfr_pkg::BK_IDLE: begin
				if (q_rvalid && out_free) begin
					unique case (q_rdata.kind)
						cfr_pkg::OP_READ: state_d = cfr_pkg::BK_READ;
						cfr_pkg::OP_COPY: state_d = cfr_pkg::BK_COPY;
						default:          state_d = cfr_pkg::BK_IDLE;
					endcase
				end
			end
			cfr_pkg::BK_READ:  state_d = out_free ? cfr_pkg::BK_IDLE : cfr_pkg::BK_READ;
			cfr_pkg::BK_COPY: begin
				state_d = (int'(col_q) == ROW_BYTES - 1) ? cfr_pkg::BK_FLUSH : cfr_pkg::BK_COPY;
			end
			cfr_pkg::BK_FLUSH: state_d = cfr_pkg::BK_RESP;
			cfr_pkg::BK_RESP:  state_d = out_free ? cfr_pkg::BK_IDLE : cfr_pkg::BK_RESP;
			default:           state_d = cfr_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop       = 1'b0;
		rd_en       = 1'b0;
		copy_done   = 1'b0;
		load_out    = 1'b0;
		load_acc    = cur_q.accepted;
		load_stored = cur_q.stored;
		load_err    = cur_q.err;
		load_data   = 8'd0;
		unique case (state_q)
			cfr_pkg::BK_IDLE: begin
				if (q_rvalid && out_free) begin
					q_pop = 1'b1;
					rd_en = (q_rdata.kind == cfr_pkg::OP_READ) && rd_ok;
					if (q_rdata.kind == cfr_pkg::OP_RESULT) begin
						load_out    = 1'b1;
						load_acc    = q_rdata.accepted;
						load_stored = q_rdata.stored;
						load_err    = q_rdata.err;
					end
				end
			end
			cfr_pkg::BK_READ: begin
				load_out  = out_free;
				load_data = rd_ok_s1 ? mem_q : 8'd0;
			end
			cfr_pkg::BK_FLUSH: copy_done = 1'b1;
			cfr_pkg::BK_RESP:  load_out  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			table_mem[wr_addr] <= col_in_frame ? buf_rdata : 8'd0;
		end
		if (rd_en) begin
			mem_q <= table_mem[rd_addr];
		end
		if (q_pop) begin
			cur_q           <= q_rdata;
			rd_ok_s1        <= rd_ok;
			row_was_valid_q <= row_valid_q[ROW_IW'(q_rdata.cmd)];
		end
		col_s1 <= col_q;
		if (load_out) begin
			out_acc_q    <= load_acc;
			out_stored_q <= load_stored;
			out_err_q    <= load_err;
			out_data_q   <= load_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfr_pkg::BK_IDLE;
			row_valid_q <= '0;
			col_q       <= '0;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_s1   <= state_q == cfr_pkg::BK_COPY;
			if (state_q == cfr_pkg::BK_COPY) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
			end
			if (copy_done) begin
				row_valid_q[row_idx] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_write_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_fire |-> (state_q == cfr_pkg::BK_COPY || state_q == cfr_pkg::BK_FLUSH))
		else $error("table write outside a frame copy");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		copy_done |=> row_valid_q[$past(row_idx)])
		else $error("copied row not marked valid");

	a_read_waits: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> state_q == cfr_pkg::BK_READ)
		else $error("table read issued without read state");

	a_col_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cfr_pkg::BK_COPY && $past(state_q) == cfr_pkg::BK_COPY) |->
		col_q == BUF_AW'($past(col_q) + 1'b1))
		else $error("copy column skipped");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the command frame receiver with an internal frame and table predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CMDS    = 16;
	localparam int MAX_LEN     = 15;
	localparam int ROW_LEN     = MAX_LEN + 3;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 216;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [7:0] LONG_HDR [4] = '{cfr_pkg::SYNC_B0, cfr_pkg::SYNC_B1,
		cfr_pkg::SYNC_B2, cfr_pkg::FRAME_ID};

	typedef struct packed {
		logic       req;
		logic [7:0] rxb;
		logic [3:0] ci;
		logic [3:0] bi;
	} link_item_t;

	typedef struct packed {
		logic       acc;
		logic       stored;
		logic       err;
		logic [7:0] rd;
	} rx_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index = cfr_pkg::CFG_SYNC_MODE;
	logic        cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // rx_byte, cmd_index, byte_index
	logic        s_tuser = 1'b0; // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // accepted, frame_stored, checksum_error, read_data

	link_item_t  link_items [$];
	rx_result_t  expected_results [$];
	rx_result_t  oldest_result;
	int          mismatches = 0;
	int          queued_items = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          cycle_count = 0;

	// predictor state
	cfr_pkg::parse_step_t step_q = cfr_pkg::ST_HUNT;
	logic [7:0]  frm_cmd = '0;
	logic [7:0]  frm_len = '0;
	logic [4:0]  frm_cnt = '0;
	logic [7:0]  frm_buf [ROW_LEN];
	logic [7:0]  cmd_tbl [NUM_CMDS][ROW_LEN];
	logic        short_hdr_mode = 1'b1;
	logic        sum_check = 1'b0;

	command_frame_receiver #(
		.NUM_CMDS(NUM_CMDS),
		.MAX_LEN (MAX_LEN)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic hunt_header(input logic [7:0] b);
		step_q = cfr_pkg::ST_HUNT;
		if (!short_hdr_mode) begin
			if (b == cfr_pkg::SYNC_B0) begin
				step_q = cfr_pkg::ST_SYNC1;
				return 1'b1;
			end
		end else if (b == cfr_pkg::SHORT_HDR) begin
			frm_buf[0] = b;
			step_q = cfr_pkg::ST_CMD;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic store_frame();
		logic ok;
		ok = (frm_cmd < NUM_CMDS) && (frm_len + 3 <= ROW_LEN);
		if (ok) begin
			for (int i = 0; i < frm_len + 3; i++)
				cmd_tbl[frm_cmd][i] = frm_buf[i];
		end
		step_q = cfr_pkg::ST_HUNT;
		return ok;
	endfunction

	function automatic rx_result_t predict_result(input link_item_t it);
		rx_result_t r;
		logic [7:0] b;
		logic [7:0] sum;
		r = '0;
		b = it.rxb;
		if (it.req) begin
			if (it.ci < NUM_CMDS && 2 + it.bi < ROW_LEN)
				r.rd = cmd_tbl[it.ci][2 + it.bi];
		end else begin
			case (step_q)
				cfr_pkg::ST_HUNT: r.acc = hunt_header(b);
				cfr_pkg::ST_SYNC1, cfr_pkg::ST_SYNC2: begin
					if (!short_hdr_mode && ((step_q == cfr_pkg::ST_SYNC1 && b == cfr_pkg::SYNC_B1) ||
							(step_q == cfr_pkg::ST_SYNC2 && b == cfr_pkg::SYNC_B2))) begin
						step_q = cfr_pkg::parse_step_t'(step_q + 1);
						r.acc = 1'b1;
					end else begin
						r.acc = hunt_header(b);
					end
				end
				cfr_pkg::ST_SYNC3: begin
					if (!short_hdr_mode && b == cfr_pkg::FRAME_ID) begin
						frm_buf[0] = b;
						step_q = cfr_pkg::ST_CMD;
						r.acc = 1'b1;
					end else begin
						r.acc = hunt_header(b);
					end
				end
				cfr_pkg::ST_CMD: begin
					frm_cmd = b;
					frm_buf[1] = b;
					step_q = cfr_pkg::ST_LEN;
					r.acc = 1'b1;
				end
				cfr_pkg::ST_LEN: begin
					if (b > MAX_LEN) begin
						step_q = cfr_pkg::ST_HUNT;
					end else begin
						frm_len = b;
						frm_buf[2] = b;
						frm_cnt = '0;
						step_q = cfr_pkg::ST_BODY;
						r.acc = 1'b1;
						if (b == 0 && !sum_check)
							r.stored = store_frame();
					end
				end
				cfr_pkg::ST_BODY: begin
					if (frm_cnt < frm_len) begin
						frm_buf[3 + frm_cnt] = b;
						frm_cnt++;
						r.acc = 1'b1;
						if (frm_cnt >= frm_len && !sum_check)
							r.stored = store_frame();
					end else if (sum_check) begin
						sum = '0;
						for (int i = 0; i < frm_len + 3; i++)
							sum += frm_buf[i];
						if (sum == b) begin
							r.stored = store_frame();
							r.acc = 1'b1;
						end else begin
							r.err = 1'b1;
							step_q = cfr_pkg::ST_HUNT;
						end
					end else begin
						r.stored = store_frame();
						r.acc = 1'b1;
					end
				end
				default: r.acc = hunt_header(b);
			endcase
		end
		return r;
	endfunction

	// sender: offers the oldest pending item, predicts it when taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				expected_results.push_back(predict_result(link_items.pop_front()));
			if (link_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {link_items[0].bi, link_items[0].ci, link_items[0].rxb};
				s_tuser  <= link_items[0].req;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none pending, expected none, got %h", $time, m_tdata);
				mismatches++;
			end else begin
				oldest_result = expected_results.pop_front();
				check_field("accepted", 8'(oldest_result.acc), 8'(m_tdata[0]));
				check_field("frame_stored", 8'(oldest_result.stored), 8'(m_tdata[1]));
				check_field("checksum_error", 8'(oldest_result.err), 8'(m_tdata[2]));
				check_field("read_data", oldest_result.rd, m_tdata[10:3]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("command_frame_receiver regression: fail");
			$finish;
		end
	end

	task automatic push_item(input logic req, input logic [7:0] b, input logic [3:0] ci,
			input logic [3:0] bi);
		link_item_t it;
		it.req = req;
		it.rxb = b;
		it.ci  = ci;
		it.bi  = bi;
		link_items.push_back(it);
		queued_items++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(1'b0, b, 4'($urandom), 4'($urandom));
	endtask

	task automatic push_read(input logic [3:0] ci, input logic [3:0] bi);
		push_item(1'b1, 8'($urandom), ci, bi);
	endtask

	// trailer: 0 none, 1 good checksum, 2 corrupted checksum
	task automatic push_frame(input logic [7:0] cmd, input logic [7:0] len, input int trailer);
		logic [7:0] sum;
		logic [7:0] b;
		if (short_hdr_mode) begin
			push_byte(cfr_pkg::SHORT_HDR);
			sum = cfr_pkg::SHORT_HDR;
		end else begin
			foreach (LONG_HDR[i])
				push_byte(LONG_HDR[i]);
			sum = cfr_pkg::FRAME_ID;
		end
		push_byte(cmd);
		push_byte(len);
		sum += cmd + len;
		for (int i = 0; i < len % (MAX_LEN + 1); i++) begin
			b = 8'($urandom);
			push_byte(b);
			sum += b;
		end
		if (trailer == 1)
			push_byte(sum);
		else if (trailer == 2)
			push_byte(sum ^ 8'($urandom_range(1, 255)));
	endtask

	task automatic push_random(input int count);
		int target;
		int pick;
		logic [7:0] cmd;
		logic [7:0] len;
		target = queued_items + count;
		while (queued_items < target) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				cmd = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NUM_CMDS - 1));
				pick = $urandom_range(19);
				if (pick == 0)
					len = 8'($urandom_range(MAX_LEN + 1, 255));
				else if (pick < 5)
					len = 8'($urandom_range(MAX_LEN));
				else
					len = 8'($urandom_range(4));
				push_frame(cmd, len, sum_check ? (($urandom_range(9) == 0) ? 2 : 1) : 0);
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 3))
					push_read(4'($urandom), 4'($urandom));
			end else if (pick < 85) begin
				pick = $urandom_range(1, 3);
				for (int i = 0; i < pick; i++)
					push_byte(LONG_HDR[i]);
				push_byte(8'($urandom));
			end else begin
				case ($urandom_range(3))
					0: push_byte(cfr_pkg::SHORT_HDR);
					1: push_byte(cfr_pkg::SYNC_B0);
					2: push_byte(cfr_pkg::FRAME_ID);
					default: push_byte(8'($urandom));
				endcase
			end
		end
	endtask

	// leave the parser mid-frame so the next settings meet it there
	task automatic push_tail();
		if (sum_check)
			push_frame(8'($urandom_range(NUM_CMDS - 1)), 8'($urandom_range(3)), 0);
		else if (!short_hdr_mode)
			push_byte(cfr_pkg::SYNC_B0);
		else
			push_byte(cfr_pkg::SHORT_HDR);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (link_items.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_config(input logic short_hdr, input logic check_sum);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= cfr_pkg::CFG_SYNC_MODE;
		cfg_data  <= short_hdr;
		do
			@(posedge clk);
		while (!cfg_ready);
		short_hdr_mode = short_hdr;
		cfg_index <= cfr_pkg::CFG_CHECKSUM_CHECK;
		cfg_data  <= check_sum;
		do
			@(posedge clk);
		while (!cfg_ready);
		sum_check = check_sum;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		foreach (frm_buf[i])
			frm_buf[i] = '0;
		foreach (cmd_tbl[i, j])
			cmd_tbl[i][j] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, at the reset settings
		push_read(4'hF, 4'hF);
		push_read(4'h0, 4'h0);
		push_frame(8'h03, 8'h00, 0);
		push_frame(8'h0F, 8'h02, 0);
		push_frame(8'h07, 8'h10, 0);
		push_frame(8'h80, 8'h01, 0);
		push_read(4'h3, 4'h0);
		push_read(4'hF, 4'h0);
		push_read(4'hF, 4'h1);
		push_read(4'hF, 4'h2);
		push_byte(8'h00);
		push_byte(8'hFF);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			write_config(1'((p % 2) ^ (p / 4)), 1'((p / 2) % 2));
			@(negedge clk);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			if (p % 4 == 0)
				hold_req++;
			push_random(PHASE_ITEMS);
			push_tail();
			wait_drained();
		end

		if (mismatches == 0)
			$display("command_frame_receiver regression: pass");
		else
			$display("command_frame_receiver regression: fail");
		$finish;
	end

endmodule

// ----- command_frame_receiver.f -----
design/cfr_pkg.sv
design/cfr_queue.sv
design/cfr_front.sv
design/cfr_back.sv
design/command_frame_receiver.sv
tb/tb_top.sv
